// File: rtl/core/assert_macros.svh
// Assertion macros used by the timer RTL (included by cdt_state).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/cdt_pkg.sv
package cdt_pkg;

    localparam int TICK_W = 20;
    localparam int SECS_W = 13;
    localparam int MIN_W  = 7;
    localparam int SEC_W  = 6;
    localparam int SEG_W  = 8;

    localparam logic [TICK_W-1:0] TPS_RESET    = 20'd1000000;
    localparam logic [TICK_W-1:0] TICK_MAX     = 20'hFFFFF;
    localparam logic [SECS_W-1:0] SECS_RESET   = 13'd300;
    localparam logic [SECS_W-1:0] SECS_MAX     = 13'd5999;
    localparam logic [SEC_W-1:0]  SECS_PER_MIN = 6'd60;
    localparam logic [SEG_W-1:0]  POINT_BIT    = 8'h80;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        bcd_t tens;
        bcd_t ones;
    } bcd_pair_t;

    typedef struct packed {
        bcd_t min_tens;
        bcd_t min_ones;
        bcd_t sec_tens;
        bcd_t sec_ones;
    } clock_digits_t;

    localparam clock_digits_t DIGITS_RESET = '{min_tens: 4'd0, min_ones: 4'd5,
                                               sec_tens: 4'd0, sec_ones: 4'd0};

    typedef struct packed {
        logic              op;
        logic [MIN_W-1:0]  load_minutes;
        logic [SEC_W-1:0]  load_seconds;
    } timer_item_t;

    typedef struct packed {
        logic [SECS_W-1:0] remaining;
        logic              minute_passed;
        logic              expired;
        clock_digits_t     digits;
    } timer_result_t;

    typedef struct packed {
        logic [SEG_W-1:0] min_tens;
        logic [SEG_W-1:0] min_ones;
        logic [SEG_W-1:0] sec_tens;
        logic [SEG_W-1:0] sec_ones;
    } seg_codes_t;

    // Split a value below 100 into two decimal digits: tens = (v * 205) >> 11.
    function automatic bcd_pair_t to_bcd(input logic [MIN_W-1:0] value);
        logic [14:0]      prod;
        bcd_t             tens;
        logic [MIN_W-1:0] tens_x10;
        logic [MIN_W-1:0] diff;
        bcd_pair_t        r;
        prod     = {8'd0, value} * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        diff     = value - tens_x10;
        r.tens   = tens;
        r.ones   = diff[3:0];
        return r;
    endfunction

    function automatic logic [SEG_W-1:0] seg_code(input bcd_t digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/core/cdt_state.sv
`include "assert_macros.svh"

module cdt_state
    import cdt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  timer_item_t         item,
    input  logic [TICK_W-1:0]   ticks_per_second,
    output timer_result_t       result_next
);

    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic [SECS_W-1:0] seconds_left_reg;
    logic [SECS_W-1:0] seconds_left_next;
    clock_digits_t     digits_reg;
    clock_digits_t     digits_next;

    logic [TICK_W-1:0] tick_inc;
    logic              fire;
    logic [SECS_W-1:0] load_total;
    logic              load_over;
    logic              load_wrap;
    logic [MIN_W-1:0]  load_min;
    logic [SEC_W-1:0]  load_sec;
    bcd_pair_t         load_min_bcd;
    bcd_pair_t         load_sec_bcd;
    clock_digits_t     dec_digits;
    logic              sec_zero;

    assign tick_inc = (tick_count_reg == TICK_MAX) ? TICK_MAX : tick_count_reg + 1'b1;
    assign fire     = !item.op && (tick_inc >= ticks_per_second)
                      && (seconds_left_reg != '0);

    assign load_total = {item.load_minutes, 6'b000000}
                        - {4'b0000, item.load_minutes, 2'b00}
                        + {7'b0000000, item.load_seconds};
    assign load_over  = load_total > SECS_MAX;
    assign load_wrap  = item.load_seconds >= SECS_PER_MIN;
    assign load_min   = item.load_minutes + {6'd0, load_wrap};
    assign load_sec   = load_wrap ? item.load_seconds - SECS_PER_MIN : item.load_seconds;
    assign load_min_bcd = to_bcd(load_min);
    assign load_sec_bcd = to_bcd({1'b0, load_sec});

    assign sec_zero = (digits_reg.sec_tens == 4'd0) && (digits_reg.sec_ones == 4'd0);

    always_comb
    begin
        dec_digits = digits_reg;
        if (digits_reg.sec_ones == 4'd0)
        begin
            dec_digits.sec_ones = 4'd9;
            if (digits_reg.sec_tens == 4'd0)
            begin
                dec_digits.sec_tens = 4'd5;
                if (digits_reg.min_ones == 4'd0)
                begin
                    dec_digits.min_ones = 4'd9;
                    dec_digits.min_tens = digits_reg.min_tens - 4'd1;
                end
                else
                begin
                    dec_digits.min_ones = digits_reg.min_ones - 4'd1;
                end
            end
            else
            begin
                dec_digits.sec_tens = digits_reg.sec_tens - 4'd1;
            end
        end
        else
        begin
            dec_digits.sec_ones = digits_reg.sec_ones - 4'd1;
        end
    end

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        seconds_left_next = seconds_left_reg;
        digits_next       = digits_reg;
        if (item.op)
        begin
            if (load_over)
            begin
                seconds_left_next = SECS_MAX;
                digits_next       = '{min_tens: 4'd9, min_ones: 4'd9,
                                      sec_tens: 4'd5, sec_ones: 4'd9};
            end
            else
            begin
                seconds_left_next    = load_total;
                digits_next.min_tens = load_min_bcd.tens;
                digits_next.min_ones = load_min_bcd.ones;
                digits_next.sec_tens = load_sec_bcd.tens;
                digits_next.sec_ones = load_sec_bcd.ones;
            end
        end
        else if (fire)
        begin
            tick_count_next   = '0;
            seconds_left_next = seconds_left_reg - 1'b1;
            digits_next       = dec_digits;
        end
        else
        begin
            tick_count_next = tick_inc;
        end
    end

    always_comb
    begin
        result_next.remaining     = seconds_left_next;
        result_next.minute_passed = fire && sec_zero;
        result_next.expired       = (seconds_left_next == '0);
        result_next.digits        = digits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            seconds_left_reg <= SECS_RESET;
            digits_reg       <= DIGITS_RESET;
        end
        else if (advance)
        begin
            tick_count_reg   <= tick_count_next;
            seconds_left_reg <= seconds_left_next;
            digits_reg       <= digits_next;
        end
    end

    `ASSERT_ALWAYS(a_digits_match_count, clk, rst_n,
        seconds_left_reg == SECS_W'((32'(digits_reg.min_tens) * 10
            + 32'(digits_reg.min_ones)) * 60 + 32'(digits_reg.sec_tens) * 10
            + 32'(digits_reg.sec_ones)))
    `ASSERT_ALWAYS(a_digits_in_range, clk, rst_n,
        digits_reg.sec_tens <= 4'd5 && digits_reg.sec_ones <= 4'd9
        && digits_reg.min_tens <= 4'd9 && digits_reg.min_ones <= 4'd9)
    `ASSERT_NEXT(a_fire_clears_prescaler, clk, rst_n, advance && fire,
        tick_count_reg == '0)

endmodule

// File: rtl/core/cdt_seg_encode.sv
module cdt_seg_encode
    import cdt_pkg::*;
(
    input  clock_digits_t digits,
    output seg_codes_t    codes
);

    always_comb
    begin
        codes.min_tens = seg_code(digits.min_tens);
        codes.min_ones = seg_code(digits.min_ones) | POINT_BIT;
        codes.sec_tens = seg_code(digits.sec_tens);
        codes.sec_ones = seg_code(digits.sec_ones);
    end

endmodule

// File: rtl/core/countdown_timer_seven_segment.sv
// Countdown timer with an MM:SS seven-segment readout.
// Input channel (in_valid / in_stall): each item is a base tick (op = 0) or a
// load of load_minutes:load_seconds (op = 1); loads above 99:59 clamp to 99:59.
// Output channel (out_valid / out_stall): one result per item with the
// remaining seconds, the minute_passed pulse, the expired flag and four
// segment codes (gfedcba, point on the minutes-ones digit).
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes
// ticks_per_second; cfg_ready is always high. Write it only while idle.
// An accepted item waits in the input register; its result is written to the output
// register when the output is not stalled. Throughput: one item per cycle while not
// stalled, set by the single state-update stage between the input and output registers.
// When the receiver stalls, the output register holds; in_stall follows
// out_stall in the same cycle once the input register holds an item, so at
// most one more item is taken while the output waits.
// Reset: count restarts at 05:00, prescaler cleared, ticks_per_second =
// 1000000, both channels empty.
module countdown_timer_seven_segment
    import cdt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TICK_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [MIN_W-1:0]    load_minutes,
    input  logic [SEC_W-1:0]    load_seconds,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SECS_W-1:0]   remaining,
    output logic                minute_passed,
    output logic                expired,
    output logic [SEG_W-1:0]    seg_min_tens,
    output logic [SEG_W-1:0]    seg_min_ones,
    output logic [SEG_W-1:0]    seg_sec_tens,
    output logic [SEG_W-1:0]    seg_sec_ones
);

    logic [TICK_W-1:0] tps_reg;
    logic              in_valid_reg;
    logic              in_valid_next;
    timer_item_t       item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    timer_result_t     result_reg;
    seg_codes_t        codes_reg;

    logic              advance;
    logic              in_accept;
    timer_result_t     result_next;
    seg_codes_t        codes_next;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next  = in_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    cdt_state u_state (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .item             (item_reg),
        .ticks_per_second (tps_reg),
        .result_next      (result_next)
    );

    cdt_seg_encode u_seg (
        .digits (result_next.digits),
        .codes  (codes_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg       <= TPS_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tps_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.op           <= op;
            item_reg.load_minutes <= load_minutes;
            item_reg.load_seconds <= load_seconds;
        end
        if (advance)
        begin
            result_reg <= result_next;
            codes_reg  <= codes_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign remaining     = result_reg.remaining;
    assign minute_passed = result_reg.minute_passed;
    assign expired       = result_reg.expired;
    assign seg_min_tens  = codes_reg.min_tens;
    assign seg_min_ones  = codes_reg.min_ones;
    assign seg_sec_tens  = codes_reg.sec_tens;
    assign seg_sec_ones  = codes_reg.sec_ones;

endmodule
